[rtl/ids_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ids_pkg
// Types and codes shared by the integer deque with search and sort.
// ----------------------------------------------------------------------------
package ids_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_FIND       = 3'd4,
        REQ_READ       = 3'd5,
        REQ_SORT       = 3'd6,
        REQ_CLEAR      = 3'd7
    } t_req_kind;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_FULL      = 3'd1;
    localparam logic [2:0] STATUS_EMPTY     = 3'd2;
    localparam logic [2:0] STATUS_RANGE     = 3'd3;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

    typedef struct packed {
        t_req_kind          req_type;
        logic signed [31:0] data_value;
        logic        [5:0]  position;
    } t_req;

    typedef struct packed {
        logic        [2:0]  status;
        logic        [5:0]  found_position;
        logic signed [31:0] read_value;
        logic        [6:0]  entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FIND,
        ST_SORT_START,
        ST_SORT_FIRST,
        ST_SORT_RUN,
        ST_SORT_TAIL
    } t_state;

endpackage
`default_nettype wire

[rtl/int_deque_search_sort.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int_deque_search_sort
// Bounded deque of signed integers with find, indexed read, sort and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on o_result for one cycle with o_done, and must be captured then.
// Push, pop and clear finish in the cycle after they are taken; read waits
// in ST_READ for the RAM data. Find streams the entry RAM one entry per
// cycle from the front until a match or the last entry. Sort runs bubble
// passes over the RAM, one entry per cycle per pass; the single RAM read
// port sets these rates. No clearing pass is needed.
module int_deque_search_sort #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    input  wire ids_pkg::t_req i_req,
    output logic         busy,
    output logic         o_done,
    output ids_pkg::t_rsp o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam int VW = VALUE_WIDTH;

    ids_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_occ, n_occ;
    logic [AW-1:0]      r_front, n_front;
    logic [AW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_lim, n_lim;
    logic [VW-1:0]      r_carry, n_carry;
    logic [VW-1:0]      r_val, n_val;
    logic               r_done, n_done;
    ids_pkg::t_rsp      r_rsp, n_rsp;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VW-1:0]      ram_rdata;

    logic [VW-1:0]      in_val;
    logic [63:0]        in_ext;
    logic [63:0]        rd_ext;
    logic [AW-1:0]      idx_inc;
    logic [AW-1:0]      idx_dec;
    logic               rd_less;

    ids_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, f} + {1'b0, p};
        if (s >= (AW+1)'(CAPACITY)) begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign in_ext  = {{32{i_req.data_value[31]}}, i_req.data_value};
    assign in_val  = in_ext[VW-1:0];
    assign rd_ext  = 64'(ram_rdata);
    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;
    assign rd_less = $signed(ram_rdata) < $signed(r_carry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ids_pkg::ST_IDLE;
            r_occ   <= '0;
            r_front <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_front <= n_front;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_lim   <= n_lim;
        r_carry <= n_carry;
        r_val   <= n_val;
        r_rsp   <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_front   = r_front;
        n_idx     = r_idx;
        n_lim     = r_lim;
        n_carry   = r_carry;
        n_val     = r_val;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = slot_of(r_front, '0);
        n_rsp.status         = ids_pkg::STATUS_OK;
        n_rsp.found_position = '0;
        n_rsp.read_value     = '0;

        case (r_state)
            ids_pkg::ST_IDLE: begin
                if (start) begin
                    n_done = 1'b1;
                    case (i_req.req_type)
                        ids_pkg::REQ_PUSH_BACK: begin
                            if (r_occ == CW'(CAPACITY)) begin
                                n_rsp.status = ids_pkg::STATUS_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_of(r_front, AW'(r_occ));
                                ram_wdata = in_val;
                                n_occ     = r_occ + 1'b1;
                            end
                        end
                        ids_pkg::REQ_PUSH_FRONT: begin
                            if (r_occ == CW'(CAPACITY)) begin
                                n_rsp.status = ids_pkg::STATUS_FULL;
                            end else begin
                                n_front   = (r_front == '0) ? AW'(CAPACITY - 1)
                                                            : r_front - 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = n_front;
                                ram_wdata = in_val;
                                n_occ     = r_occ + 1'b1;
                            end
                        end
                        ids_pkg::REQ_POP_BACK: begin
                            if (r_occ == '0) begin
                                n_rsp.status = ids_pkg::STATUS_EMPTY;
                            end else begin
                                n_occ = r_occ - 1'b1;
                            end
                        end
                        ids_pkg::REQ_POP_FRONT: begin
                            if (r_occ == '0) begin
                                n_rsp.status = ids_pkg::STATUS_EMPTY;
                            end else begin
                                n_occ   = r_occ - 1'b1;
                                n_front = slot_of(r_front, AW'(1));
                            end
                        end
                        ids_pkg::REQ_FIND: begin
                            if (r_occ == '0) begin
                                n_rsp.status = ids_pkg::STATUS_NOT_FOUND;
                            end else begin
                                n_done  = 1'b0;
                                n_val   = in_val;
                                n_idx   = '0;
                                n_state = ids_pkg::ST_FIND;
                            end
                        end
                        ids_pkg::REQ_READ: begin
                            if (r_occ == '0) begin
                                n_rsp.status = ids_pkg::STATUS_EMPTY;
                            end else if (XW'(i_req.position) >= XW'(r_occ)) begin
                                n_rsp.status = ids_pkg::STATUS_RANGE;
                            end else begin
                                n_done    = 1'b0;
                                ram_raddr = slot_of(r_front, AW'(i_req.position));
                                n_state   = ids_pkg::ST_READ;
                            end
                        end
                        ids_pkg::REQ_SORT: begin
                            if (r_occ > CW'(1)) begin
                                n_done  = 1'b0;
                                n_lim   = r_occ;
                                n_state = ids_pkg::ST_SORT_FIRST;
                            end
                        end
                        ids_pkg::REQ_CLEAR: begin
                            n_occ   = '0;
                            n_front = '0;
                        end
                        default: begin
                            n_rsp.status = ids_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ids_pkg::ST_READ: begin
                n_done           = 1'b1;
                n_rsp.read_value = rd_ext[31:0];
                n_state          = ids_pkg::ST_IDLE;
            end
            ids_pkg::ST_FIND: begin
                if (ram_rdata == r_val) begin
                    n_done               = 1'b1;
                    n_rsp.found_position = 6'(r_idx);
                    n_state              = ids_pkg::ST_IDLE;
                end else if (CW'(idx_inc) < r_occ && idx_inc != '0) begin
                    ram_raddr = slot_of(r_front, idx_inc);
                    n_idx     = idx_inc;
                end else begin
                    n_done       = 1'b1;
                    n_rsp.status = ids_pkg::STATUS_NOT_FOUND;
                    n_state      = ids_pkg::ST_IDLE;
                end
            end
            ids_pkg::ST_SORT_START: begin
                n_state = ids_pkg::ST_SORT_FIRST;
            end
            ids_pkg::ST_SORT_FIRST: begin
                n_carry   = ram_rdata;
                ram_raddr = slot_of(r_front, AW'(1));
                n_idx     = AW'(1);
                n_state   = ids_pkg::ST_SORT_RUN;
            end
            ids_pkg::ST_SORT_RUN: begin
                // the larger value bubbles on, the smaller lands one slot back
                ram_we    = 1'b1;
                ram_waddr = slot_of(r_front, idx_dec);
                ram_wdata = rd_less ? ram_rdata : r_carry;
                n_carry   = rd_less ? r_carry : ram_rdata;
                if (CW'(idx_inc) < r_lim && idx_inc != '0) begin
                    ram_raddr = slot_of(r_front, idx_inc);
                    n_idx     = idx_inc;
                end else begin
                    n_state = ids_pkg::ST_SORT_TAIL;
                end
            end
            ids_pkg::ST_SORT_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(r_front, r_idx);
                ram_wdata = r_carry;
                n_lim     = r_lim - 1'b1;
                if (n_lim > CW'(1)) begin
                    n_state = ids_pkg::ST_SORT_START;
                end else begin
                    n_done  = 1'b1;
                    n_state = ids_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ids_pkg::ST_IDLE;
            end
        endcase

        n_rsp.entry_count = 7'(n_occ);
    end

    assign busy     = (r_state != ids_pkg::ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_rsp;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.req_type == ids_pkg::REQ_PUSH_BACK ||
         i_req.req_type == ids_pkg::REQ_POP_FRONT ||
         i_req.req_type == ids_pkg::REQ_CLEAR)) |=> (o_done && !busy))
        else $error("simple request did not finish in one cycle");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.entry_count == 7'(r_occ)))
        else $error("reported count differs from occupancy");

    a_occ_stable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_occ))
        else $error("occupancy changed during a long request");
`endif

endmodule
`default_nettype wire

[rtl/ids_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ids_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

[tb/sv/int_deque_search_sort_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_deque_search_sort_tb
// Self-checking bench for the integer deque with search and sort: a short
// table of directed requests, then biased random grow/shrink traffic with
// sender gaps; results checked against the table row or a local deque model.
// ----------------------------------------------------------------------------
module int_deque_search_sort_tb;
    import ids_pkg::*;

    localparam int DEPTH       = 64;
    localparam int N_RANDOM    = 1580;
    localparam int CYCLE_LIMIT = 20_000_000;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } dir_row_t;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_done;
    t_rsp  o_result;

    // deque model state
    logic signed [31:0] deque_mem [DEPTH];
    int                 front_ptr;
    int                 occ_cnt;

    t_rsp     rsp_expect_q [$];
    dir_row_t dir_tab [$];
    bit       failed    = 1'b0;
    int       cycle_cnt = 0;
    int       idle_pct;

    int_deque_search_sort u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t timeout", $realtime);
            $display("int_deque_search_sort: mismatch");
            $finish;
        end
    end

    task automatic deque_apply(input t_req r, output t_rsp o);
        logic signed [31:0] vals [DEPTH];
        logic signed [31:0] tmp;
        o = '0;
        o.status = STATUS_OK;
        case (r.req_type)
            REQ_PUSH_BACK: begin
                if (occ_cnt >= DEPTH) begin
                    o.status = STATUS_FULL;
                end else begin
                    deque_mem[(front_ptr + occ_cnt) % DEPTH] = r.data_value;
                    occ_cnt++;
                end
            end
            REQ_PUSH_FRONT: begin
                if (occ_cnt >= DEPTH) begin
                    o.status = STATUS_FULL;
                end else begin
                    front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
                    deque_mem[front_ptr] = r.data_value;
                    occ_cnt++;
                end
            end
            REQ_POP_BACK: begin
                if (occ_cnt == 0) o.status = STATUS_EMPTY;
                else occ_cnt--;
            end
            REQ_POP_FRONT: begin
                if (occ_cnt == 0) begin
                    o.status = STATUS_EMPTY;
                end else begin
                    front_ptr = (front_ptr + 1) % DEPTH;
                    occ_cnt--;
                end
            end
            REQ_FIND: begin
                o.status = STATUS_NOT_FOUND;
                for (int i = 0; i < occ_cnt; i++) begin
                    if (o.status != STATUS_OK &&
                        deque_mem[(front_ptr + i) % DEPTH] == r.data_value) begin
                        o.status = STATUS_OK;
                        o.found_position = i[5:0];
                    end
                end
            end
            REQ_READ: begin
                if (occ_cnt == 0) o.status = STATUS_EMPTY;
                else if (int'(r.position) >= occ_cnt) o.status = STATUS_RANGE;
                else o.read_value = deque_mem[(front_ptr + r.position) % DEPTH];
            end
            REQ_SORT: begin
                for (int i = 0; i < occ_cnt; i++) vals[i] = deque_mem[(front_ptr + i) % DEPTH];
                for (int i = 0; i + 1 < occ_cnt; i++) begin
                    for (int j = 0; j + 1 < occ_cnt - i; j++) begin
                        if (vals[j+1] < vals[j]) begin
                            tmp       = vals[j];
                            vals[j]   = vals[j+1];
                            vals[j+1] = tmp;
                        end
                    end
                end
                for (int i = 0; i < occ_cnt; i++) deque_mem[(front_ptr + i) % DEPTH] = vals[i];
            end
            default: begin
                occ_cnt   = 0;
                front_ptr = 0;
            end
        endcase
        o.entry_count = occ_cnt[6:0];
    endtask

    // drive one request, hold until taken, then maybe leave a gap
    task automatic issue_request(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp pred;
        i_req <= r;
        start <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        deque_apply(r, pred);
        rsp_expect_q.push_back(typed ? typed_rsp : pred);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_done) begin
            if (rsp_expect_q.size() == 0) begin
                $display("%0t unexpected result, actual %p", $realtime, o_result);
                failed = 1'b1;
            end else begin
                exp_rsp = rsp_expect_q.pop_front();
                if (o_result.status !== exp_rsp.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $realtime, exp_rsp.status, o_result.status);
                    failed = 1'b1;
                end
                if (o_result.found_position !== exp_rsp.found_position) begin
                    $display("%0t found_position: expected %0d actual %0d",
                             $realtime, exp_rsp.found_position, o_result.found_position);
                    failed = 1'b1;
                end
                if (o_result.read_value !== exp_rsp.read_value) begin
                    $display("%0t read_value: expected %0d actual %0d",
                             $realtime, exp_rsp.read_value, o_result.read_value);
                    failed = 1'b1;
                end
                if (o_result.entry_count !== exp_rsp.entry_count) begin
                    $display("%0t entry_count: expected %0d actual %0d",
                             $realtime, exp_rsp.entry_count, o_result.entry_count);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic dir_row_t mk_row(t_req_kind k, logic signed [31:0] v,
                                        logic [5:0] p, bit typed, logic [2:0] st,
                                        logic [5:0] fp, logic signed [31:0] rv,
                                        logic [6:0] cnt);
        dir_row_t row;
        row.req   = '{req_type: k, data_value: v, position: p};
        row.typed = typed;
        row.rsp   = '{status: st, found_position: fp, read_value: rv, entry_count: cnt};
        return row;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1: return $signed($urandom_range(8)) - 32'sd4;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic t_req pick_request(bit grow);
        t_req r;
        int   roll;
        roll         = $urandom_range(99);
        r.data_value = pick_value();
        r.position   = 6'($urandom_range(63));
        if (roll < 2)       r.req_type = REQ_CLEAR;
        else if (roll < 6)  r.req_type = REQ_SORT;
        else if (roll < 18) r.req_type = REQ_FIND;
        else if (roll < 30) r.req_type = REQ_READ;
        else if (roll < 65) r.req_type = grow ? (roll[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT)
                                              : (roll[0] ? REQ_POP_BACK : REQ_POP_FRONT);
        else                r.req_type = t_req_kind'($urandom_range(3));
        // mostly hit live entries for find and read
        if (occ_cnt > 0 && $urandom_range(99) < 65) begin
            r.position = 6'($urandom_range(occ_cnt - 1));
            if (r.req_type == REQ_FIND)
                r.data_value = deque_mem[(front_ptr + $urandom_range(occ_cnt - 1)) % DEPTH];
        end
        return r;
    endfunction

    initial begin
        bit grow;
        front_ptr = 0;
        occ_cnt   = 0;
        idle_pct  = 33;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tab.push_back(mk_row(REQ_POP_BACK,  0, 0, 1, STATUS_EMPTY, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_POP_FRONT, 0, 0, 1, STATUS_EMPTY, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_READ,      0, 0, 1, STATUS_EMPTY, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_FIND,      0, 0, 1, STATUS_NOT_FOUND, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_SORT,      0, 0, 1, STATUS_OK, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_CLEAR,     0, 0, 1, STATUS_OK, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_PUSH_BACK, 32'sh7fffffff, 6'd63, 1, STATUS_OK, 0, 0, 1));
        dir_tab.push_back(mk_row(REQ_PUSH_FRONT, 32'sh80000000, 0, 1, STATUS_OK, 0, 0, 2));
        dir_tab.push_back(mk_row(REQ_READ, 0, 0, 1, STATUS_OK, 0, 32'sh80000000, 2));
        dir_tab.push_back(mk_row(REQ_READ, -1, 1, 1, STATUS_OK, 0, 32'sh7fffffff, 2));
        dir_tab.push_back(mk_row(REQ_READ, 0, 2, 1, STATUS_RANGE, 0, 0, 2));
        dir_tab.push_back(mk_row(REQ_READ, 0, 6'd63, 1, STATUS_RANGE, 0, 0, 2));
        dir_tab.push_back(mk_row(REQ_FIND, 32'sh7fffffff, 0, 1, STATUS_OK, 1, 0, 2));
        dir_tab.push_back(mk_row(REQ_FIND, 5, 0, 1, STATUS_NOT_FOUND, 0, 0, 2));
        dir_tab.push_back(mk_row(REQ_PUSH_BACK, -1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_PUSH_FRONT, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_PUSH_BACK, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_PUSH_BACK, -1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_SORT, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_READ, 0, 5, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_FIND, -1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_POP_BACK, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_POP_FRONT, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(REQ_CLEAR, 0, 0, 1, STATUS_OK, 0, 0, 0));
        foreach (dir_tab[i]) issue_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

        // grow/shrink bias flips so the deque reaches both full and empty
        grow = 1'b1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                idle_pct = 58;
                start <= 1'b0;
                while (rsp_expect_q.size() != 0) @(posedge i_clk);
            end
            if (n == 2 * N_RANDOM / 3) idle_pct = 0;
            if (occ_cnt >= DEPTH && $urandom_range(3) == 0) grow = 1'b0;
            if (occ_cnt == 0 && $urandom_range(3) == 0) grow = 1'b1;
            if ($urandom_range(149) == 0) grow = ~grow;
            issue_request(pick_request(grow), 1'b0, '0);
        end
        start <= 1'b0;

        while (rsp_expect_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (!failed) begin
            $display("int_deque_search_sort: match");
        end else begin
            $display("int_deque_search_sort: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ids_pkg.sv
rtl/ids_ram.sv
rtl/int_deque_search_sort.sv
tb/sv/int_deque_search_sort_tb.sv
